// ----- rtl/chordal_direction_residual_defines.svh -----
// Assertion macros used by the checker file.
`ifndef CHORDAL_DIRECTION_RESIDUAL_DEFINES_SVH
`define CHORDAL_DIRECTION_RESIDUAL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cdr_pkg.sv -----
// Shared constants for the chordal direction residual pipeline.
package cdr_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int WEIGHT_W        = 31;
  localparam int RES_W           = 32;
  localparam int NORM_W          = 30;
  localparam int SQ_W            = 2 * NORM_W;
  localparam int SUM_W           = SQ_W + 2;
  localparam int ROOT_W          = SUM_W / 2;
endpackage

// ----- rtl/cdr_front.sv -----
// Difference, common normalisation shift and sum of squares (six stages).
module cdr_front import cdr_pkg::*; #(
  parameter int CW     = COORD_WIDTH_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [2:0][CW-1:0]           from_i,
  input  logic [2:0][CW-1:0]           to_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         vld_o,
  output logic [2:0][NORM_W-1:0]       mag_o,
  output logic [2:0]                   neg_o,
  output logic                         zero_o,
  output logic [SUM_W-1:0]             sum_o,
  output logic [SIDE_W-1:0]            side_o
);
  localparam int MW = CW + 1;
  localparam int PW = $clog2(MW);

  logic [5:0]              vld_q;
  logic [MW-1:0]           diff_d [3];
  logic [2:0][MW-1:0]      mag1_q, mag2_q, mag3_q;
  logic [2:0][MW-1:0]      mag1_d;
  logic [2:0]              neg1_q, neg2_q, neg3_q, neg4_q, neg5_q, neg6_q;
  logic [SIDE_W-1:0]       side1_q, side2_q, side3_q, side4_q, side5_q, side6_q;
  logic [MW-1:0]           ora2_q;
  logic [PW-1:0]           pos_d, pos3_q;
  logic                    zero3_q, zero4_q, zero5_q, zero6_q;
  logic [2:0][NORM_W-1:0]  e4_q, e5_q, e6_q;
  logic [2:0][SQ_W-1:0]    sq5_q;
  logic [SUM_W-1:0]        sum6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_d[i] = MW'($signed({to_i[i][CW-1], to_i[i]}) - $signed({from_i[i][CW-1], from_i[i]}));
      mag1_d[i] = diff_d[i][MW-1] ? MW'(-diff_d[i]) : diff_d[i];
    end
  end

  always_comb begin
    pos_d = '0;
    for (int k = 0; k < MW; k++) begin
      if (ora2_q[k]) pos_d = PW'(k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= diff_d[i][MW-1];
        e4_q[i]   <= NORM_W'({mag3_q[i], {(NORM_W-1){1'b0}}} >> pos3_q);
        sq5_q[i]  <= e4_q[i] * e4_q[i];
      end
      mag1_q  <= mag1_d;
      side1_q <= side_i;
      ora2_q  <= mag1_q[0] | mag1_q[1] | mag1_q[2];
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      side2_q <= side1_q;
      pos3_q  <= pos_d;
      zero3_q <= (ora2_q == '0);
      mag3_q  <= mag2_q;
      neg3_q  <= neg2_q;
      side3_q <= side2_q;
      zero4_q <= zero3_q;
      neg4_q  <= neg3_q;
      side4_q <= side3_q;
      e5_q    <= e4_q;
      zero5_q <= zero4_q;
      neg5_q  <= neg4_q;
      side5_q <= side4_q;
      sum6_q  <= SUM_W'(sq5_q[0]) + SUM_W'(sq5_q[1]) + SUM_W'(sq5_q[2]);
      e6_q    <= e5_q;
      zero6_q <= zero5_q;
      neg6_q  <= neg5_q;
      side6_q <= side5_q;
    end
  end

  assign vld_o  = vld_q[5];
  assign mag_o  = e6_q;
  assign neg_o  = neg6_q;
  assign zero_o = zero6_q;
  assign sum_o  = sum6_q;
  assign side_o = side6_q;
endmodule

// ----- rtl/cdr_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module cdr_isqrt import cdr_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [SUM_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               vld_o,
  output logic [ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]  side_o
);
  logic [SUM_W-1:0]  rad_q  [ROOT_W];
  logic [SUM_W-1:0]  root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic [ROOT_W-1:0] vld_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SUM_W-1:0]  rad_in, root_in, trial;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = root_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if (rad_in >= trial) begin
          rad_q[k]  <= rad_in - trial;
          root_q[k] <= (root_in >> 1) + BIT;
        end else begin
          rad_q[k]  <= rad_in;
          root_q[k] <= root_in >> 1;
        end
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = ROOT_W'(root_q[ROOT_W-1]);
  assign side_o = side_q[ROOT_W-1];
endmodule

// ----- rtl/cdr_div.sv -----
// Three-lane restoring divider, one quotient bit per stage, rounded.
module cdr_div import cdr_pkg::*; #(
  parameter int FB     = FRAC_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [2:0][NORM_W-1:0]  mag_i,
  input  logic [ROOT_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    vld_o,
  output logic [2:0][FB:0]        quo_o,
  output logic [SIDE_W-1:0]       side_o
);
  localparam int S  = FB + 1;
  localparam int RW = FB + NORM_W + 1;
  localparam int QW = FB + 1;

  logic [2:0][RW-1:0] rem_q  [S];
  logic [2:0][QW-1:0] quo_q  [S];
  logic [ROOT_W-1:0]  den_q  [S];
  logic [SIDE_W-1:0]  side_q [S];
  logic [S-1:0]       vld_q;

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [2:0][RW-1:0] rem_in;
    logic [2:0][QW-1:0] quo_in;
    logic [ROOT_W-1:0]  den_in;
    logic [SIDE_W-1:0]  side_in;
    logic               vld_in;
    logic [RW-1:0]      dvs;

    if (s == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = (RW'(mag_i[i]) << FB) + RW'(den_i >> 1);
        end
      end
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign dvs = RW'(den_in) << (FB - s);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dvs) begin
            rem_q[s][i] <= rem_in[i] - dvs;
            quo_q[s][i] <= {quo_in[i][QW-2:0], 1'b1};
          end else begin
            rem_q[s][i] <= rem_in[i];
            quo_q[s][i] <= {quo_in[i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign vld_o  = vld_q[S-1];
  assign quo_o  = quo_q[S-1];
  assign side_o = side_q[S-1];
endmodule

// ----- rtl/cdr_back.sv -----
// Direction error, weighting, rounding and saturation (three stages).
module cdr_back import cdr_pkg::*; #(
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [2:0][FB:0]       quo_i,
  input  logic [2:0]             neg_i,
  input  logic [2:0][FB+1:0]     dir_i,
  input  logic [WEIGHT_W-1:0]    w_i,
  input  logic                   zero_i,
  output logic                   vld_o,
  output logic [2:0][RES_W-1:0]  res_o,
  output logic                   zero_o
);
  localparam int DFW = FB + 3;
  localparam int DMW = FB + 2;
  localparam int PMW = DMW + WEIGHT_W;
  localparam int RMW = PMW + 1 - FB;
  localparam logic [PMW:0]   HALF    = (PMW+1)'(1) << (FB - 1);
  localparam logic [RMW-1:0] NEG_MAX = RMW'(1) << (RES_W - 1);
  localparam logic [RMW-1:0] POS_MAX = NEG_MAX - RMW'(1);

  logic [2:0]             vld_q;
  logic [DFW-1:0]         diff_d [3];
  logic [2:0]             pneg1_q, pneg2_q;
  logic [2:0][DMW-1:0]    dm1_q;
  logic [2:0][PMW-1:0]    pm2_q;
  logic [WEIGHT_W-1:0]    w1_q;
  logic                   zero1_q, zero2_q, zero3_q;
  logic [RMW-1:0]         rm_d [3];
  logic [2:0][RES_W-1:0]  res_d, res3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_d[i] = (neg_i[i] ? DFW'(-$signed({1'b0, quo_i[i]})) : DFW'({1'b0, quo_i[i]}))
                - DFW'($signed(dir_i[i]));
      rm_d[i]   = RMW'(((PMW+1)'(pm2_q[i]) + HALF) >> FB);
      if (zero2_q) begin
        res_d[i] = '0;
      end else if (pneg2_q[i]) begin
        res_d[i] = RES_W'(-((rm_d[i] > NEG_MAX) ? NEG_MAX : rm_d[i]));
      end else begin
        res_d[i] = RES_W'((rm_d[i] > POS_MAX) ? POS_MAX : rm_d[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pneg1_q[i] <= diff_d[i][DFW-1];
        dm1_q[i]   <= diff_d[i][DFW-1] ? DMW'(-diff_d[i]) : DMW'(diff_d[i]);
        pm2_q[i]   <= PMW'(dm1_q[i]) * PMW'(w1_q);
      end
      w1_q    <= w_i;
      zero1_q <= zero_i;
      pneg2_q <= pneg1_q;
      zero2_q <= zero1_q;
      res3_q  <= res_d;
      zero3_q <= zero2_q;
    end
  end

  assign vld_o  = vld_q[2];
  assign res_o  = res3_q;
  assign zero_o = zero3_q;
endmodule

// ----- rtl/chordal_direction_residual.sv -----
// Pipeline sections, in order: front, root, divide, back.
// Throughput: one beat per cycle while the output is not stalled; the root and divider stages are fully pipelined.
// A stalled output beat freezes the whole pipeline; in_stall_o is high only while it lasts.
// Reset: rst_ni asynchronous, active low, clears all valid bits; data registers are not reset.
module chordal_direction_residual import cdr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COORD_WIDTH-1:0] from_x_i,
  input  logic [COORD_WIDTH-1:0] from_y_i,
  input  logic [COORD_WIDTH-1:0] from_z_i,
  input  logic [COORD_WIDTH-1:0] to_x_i,
  input  logic [COORD_WIDTH-1:0] to_y_i,
  input  logic [COORD_WIDTH-1:0] to_z_i,
  input  logic [FRAC_BITS+1:0]   dir_x_i,
  input  logic [FRAC_BITS+1:0]   dir_y_i,
  input  logic [FRAC_BITS+1:0]   dir_z_i,
  input  logic [WEIGHT_W-1:0]    edge_weight_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [RES_W-1:0]       res_x_o,
  output logic [RES_W-1:0]       res_y_o,
  output logic [RES_W-1:0]       res_z_o,
  output logic                   zero_length_o
);
  localparam int DW  = FRAC_BITS + 2;
  localparam int SW0 = WEIGHT_W + 3 * DW;
  localparam int SW1 = SW0 + 4 + 3 * NORM_W;
  localparam int SW2 = SW0 + 4;

  logic                   en;
  logic                   f_vld, r_vld, d_vld;
  logic [2:0][NORM_W-1:0] f_mag, r_mag;
  logic [2:0]             f_neg, r_neg, d_neg;
  logic                   f_zero, r_zero, d_zero;
  logic [SUM_W-1:0]       f_sum;
  logic [SW0-1:0]         f_side, r_side0, d_side0;
  logic [SW1-1:0]         r_side;
  logic [SW2-1:0]         d_side;
  logic [ROOT_W-1:0]      r_root;
  logic [2:0][FRAC_BITS:0] d_quo;
  logic [2:0][DW-1:0]     d_dir;
  logic [2:0][RES_W-1:0]  res;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  cdr_front #(.CW(COORD_WIDTH), .SIDE_W(SW0)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .from_i({from_z_i, from_y_i, from_x_i}),
    .to_i  ({to_z_i, to_y_i, to_x_i}),
    .side_i({edge_weight_i, dir_z_i, dir_y_i, dir_x_i}),
    .vld_o(f_vld), .mag_o(f_mag), .neg_o(f_neg), .zero_o(f_zero),
    .sum_o(f_sum), .side_o(f_side)
  );

  cdr_isqrt #(.SIDE_W(SW1)) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(f_vld), .rad_i(f_sum),
    .side_i({f_side, f_neg, f_zero, f_mag}),
    .vld_o(r_vld), .root_o(r_root), .side_o(r_side)
  );

  assign {r_side0, r_neg, r_zero, r_mag} = r_side;

  cdr_div #(.FB(FRAC_BITS), .SIDE_W(SW2)) u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(r_vld), .mag_i(r_mag), .den_i(r_root),
    .side_i({r_side0, r_neg, r_zero}),
    .vld_o(d_vld), .quo_o(d_quo), .side_o(d_side)
  );

  assign {d_side0, d_neg, d_zero} = d_side;
  assign d_dir = d_side0[3*DW-1:0];

  cdr_back #(.FB(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .en_i(en), .vld_i(d_vld), .quo_i(d_quo), .neg_i(d_neg),
    .dir_i(d_dir), .w_i(d_side0[SW0-1:3*DW]), .zero_i(d_zero),
    .vld_o(out_valid_o), .res_o(res), .zero_o(zero_length_o)
  );

  assign res_x_o = res[0];
  assign res_y_o = res[1];
  assign res_z_o = res[2];
endmodule

// ----- rtl/cdr_checker.sv -----
// Port-level checks for the residual pipeline, bound to the top level.
`include "chordal_direction_residual_defines.svh"
module cdr_checker import cdr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [RES_W-1:0] res_x_o,
  input logic [RES_W-1:0] res_y_o,
  input logic [RES_W-1:0] res_z_o,
  input logic             zero_length_o
);
  `CDR_ASSERT_NOW(a_zero_res, out_valid_o && zero_length_o, res_x_o == '0 && res_y_o == '0 && res_z_o == '0, "coincident nodes gave a non-zero residual")
  `CDR_ASSERT_NOW(a_stall_src, in_stall_o, out_valid_o && out_stall_i, "input stalled without a stalled output beat")
  `CDR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "stalled output beat dropped")
  `CDR_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(res_x_o) && $stable(res_y_o) && $stable(res_z_o) && $stable(zero_length_o), "stalled output beat changed")
endmodule

bind chordal_direction_residual cdr_checker u_cdr_checker (.*);
